FILE: design/wloa_pkg.sv
package wloa_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int WIN_SLOTS   = 32;
	localparam int WIN_W       = 5;
	localparam int LIMIT_W     = 6;
	localparam int RUN_W       = 24;
	localparam int LEN_W       = 16;
	localparam int LEVEL_W     = 16;
	localparam int ACC_W       = 46;
	localparam int TOTAL_W     = 21;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 24;

	// window mean square never exceeds 2^30, so the quotient fits 31 bits
	localparam int MEAN_W      = 31;
	localparam int RAD_W       = 32;
	localparam int ROOT_REM_W  = 18;
	localparam int DIV_STEPS   = MEAN_W;
	localparam int ROOT_STEPS  = RAD_W / 2;
	localparam int AVG_STEPS   = TOTAL_W;
	localparam int STEP_W      = 5;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = 2;
	localparam int QUEUE_CNT_W = 3;

	localparam logic [RUN_W-1:0]   RESET_SAMPLES_PER_RUN = 24'd48000;
	localparam logic [LEN_W-1:0]   RESET_WINDOW_LENGTH   = 16'd1024;
	localparam logic [LIMIT_W-1:0] RESET_WINDOW_LIMIT    = 6'd32;
	localparam logic [LEVEL_W-1:0] RESET_SILENCE_LEVEL   = 16'd328;
	localparam logic [LEVEL_W-1:0] RESET_ONSET_RISE      = 16'd3277;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SAMPLES_PER_RUN = 3'd0,
		CFG_WINDOW_LENGTH   = 3'd1,
		CFG_WINDOW_LIMIT    = 3'd2,
		CFG_SILENCE_LEVEL   = 3'd3,
		CFG_ONSET_RISE      = 3'd4
	} cfg_index_t;

	typedef struct packed {
		logic [RUN_W-1:0]   run_len;
		logic [LEN_W-1:0]   win_len;
		logic [LIMIT_W-1:0] win_limit;
	} front_cfg_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] silence;
		logic [LEVEL_W-1:0] rise;
	} back_cfg_t;

	// one closed window handed from front to back
	typedef struct packed {
		logic [ACC_W-1:0]   acc;
		logic [LEN_W-1:0]   count;
		logic [LEVEL_W-1:0] peak;
		logic [WIN_W-1:0]   win;
		logic               last;
	} job_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_ROOT,
		ST_UPD,
		ST_AVG,
		ST_DONE
	} state_t;

endpackage

FILE: design/wloa_front.sv
module wloa_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [wloa_pkg::SAMPLE_W-1:0] sample,
	input  wloa_pkg::front_cfg_t                cfg,
	input  logic                                queue_near_full,
	output logic                                push,
	output wloa_pkg::job_t                      push_job
);
	import wloa_pkg::*;

	logic [RUN_W-1:0]   run_pos_q;
	logic [LEN_W-1:0]   win_pos_q;
	logic [LIMIT_W-1:0] cur_win_q;
	logic [ACC_W-1:0]   acc_q;
	logic [LEVEL_W-1:0] peak_q;

	logic               valid_s1;
	logic [LEVEL_W-1:0] mag_s1;
	logic               active_s1;
	logic               close_s1;
	logic               clear_s1;
	logic [LEN_W-1:0]   count_s1;
	logic [WIN_W-1:0]   win_s1;
	logic               last_s1;

	logic               accept;
	logic [SAMPLE_W-1:0] sample_u;
	logic [LEVEL_W-1:0] mag;
	logic [RUN_W-1:0]   run_len;
	logic [LEN_W-1:0]   win_len;
	logic [LIMIT_W-1:0] limit;
	logic               run_end;
	logic               active;
	logic [LEN_W-1:0]   pos_next;
	logic               close;
	logic               last;

	logic [2*LEVEL_W-1:0] square;
	logic [ACC_W-1:0]   acc_sum;
	logic [LEVEL_W-1:0] peak_next;

	assign in_stall = queue_near_full;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		sample_u = unsigned'(sample);
		mag      = sample_u[SAMPLE_W-1] ? LEVEL_W'(~sample_u + 1'b1) : LEVEL_W'(sample_u);
		run_len  = (cfg.run_len == '0) ? RUN_W'(1) : cfg.run_len;
		win_len  = (cfg.win_len == '0) ? LEN_W'(1) : cfg.win_len;
		if (cfg.win_limit == '0) begin
			limit = LIMIT_W'(1);
		end else if (cfg.win_limit > LIMIT_W'(WIN_SLOTS)) begin
			limit = LIMIT_W'(WIN_SLOTS);
		end else begin
			limit = cfg.win_limit;
		end
		run_end  = ({1'b0, run_pos_q} + (RUN_W + 1)'(1)) >= {1'b0, run_len};
		active   = cur_win_q < limit;
		pos_next = win_pos_q + LEN_W'(1);
		close    = active && ((pos_next >= win_len) || run_end);
		last     = run_end || (({1'b0, cur_win_q} + (LIMIT_W + 1)'(1)) >= {1'b0, limit});
	end

	// run and window counters advance at acceptance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_pos_q <= '0;
			win_pos_q <= '0;
			cur_win_q <= '0;
		end else if (accept) begin
			if (run_end) begin
				run_pos_q <= '0;
				win_pos_q <= '0;
				cur_win_q <= '0;
			end else begin
				run_pos_q <= run_pos_q + RUN_W'(1);
				if (active) begin
					if (close) begin
						win_pos_q <= '0;
						cur_win_q <= cur_win_q + LIMIT_W'(1);
					end else begin
						win_pos_q <= pos_next;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mag_s1    <= mag;
			active_s1 <= active;
			close_s1  <= close;
			clear_s1  <= run_end;
			count_s1  <= pos_next;
			win_s1    <= cur_win_q[WIN_W-1:0];
			last_s1   <= last;
		end
	end

	always_comb begin
		square    = mag_s1 * mag_s1;
		acc_sum   = acc_q + ACC_W'(square);
		peak_next = (mag_s1 > peak_q) ? mag_s1 : peak_q;
	end

	// second stage: square and accumulate, hand closed windows to the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			peak_q <= '0;
		end else if (valid_s1) begin
			if (close_s1 || clear_s1) begin
				acc_q  <= '0;
				peak_q <= '0;
			end else if (active_s1) begin
				acc_q  <= acc_sum;
				peak_q <= peak_next;
			end
		end
	end

	assign push           = valid_s1 && close_s1;
	assign push_job.acc   = acc_sum;
	assign push_job.count = count_s1;
	assign push_job.peak  = peak_next;
	assign push_job.win   = win_s1;
	assign push_job.last  = last_s1;

endmodule

FILE: design/wloa_fifo.sv
module wloa_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  wloa_pkg::job_t push_job,
	output logic           near_full,
	input  logic           pop,
	output logic           avail,
	output wloa_pkg::job_t pop_job
);
	import wloa_pkg::*;

	job_t                   entry_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;

	// leave one slot for the window still in the front's second stage
	assign near_full = count_q >= QUEUE_CNT_W'(QUEUE_DEPTH - 1);
	assign avail     = count_q != '0;
	assign pop_job   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QUEUE_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QUEUE_CNT_W'(1);
			end
		end
	end

endmodule

FILE: design/wloa_back.sv
module wloa_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  wloa_pkg::back_cfg_t                cfg,
	input  logic                               avail,
	input  wloa_pkg::job_t                     job,
	output logic                               pop,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [wloa_pkg::WIN_W-1:0]         window_number,
	output logic [wloa_pkg::LEVEL_W-1:0]       window_rms,
	output logic [wloa_pkg::LEVEL_W-1:0]       window_peak,
	output logic                               silent_flag,
	output logic                               onset_flag,
	output logic [wloa_pkg::WIN_SLOTS-1:0]     silent_bits,
	output logic [wloa_pkg::WIN_SLOTS-1:0]     onset_bits,
	output logic [wloa_pkg::LEVEL_W-1:0]       average_rms,
	output logic [wloa_pkg::LEVEL_W-1:0]       average_peak,
	output logic [wloa_pkg::LEVEL_W-1:0]       highest_rms,
	output logic [wloa_pkg::LEVEL_W-1:0]       highest_peak,
	output logic                               final_window
);
	import wloa_pkg::*;

	state_t state_q;
	state_t state_next;

	logic [STEP_W-1:0]     step_q;
	logic [LEN_W-1:0]      den_q;
	logic [LEN_W-1:0]      rem_q;
	logic [MEAN_W-1:0]     quo_q;
	logic [RAD_W-1:0]      rad_q;
	logic [ROOT_REM_W-1:0] srem_q;
	logic [LEVEL_W-1:0]    root_q;
	logic [WIN_W-1:0]      win_q;
	logic                  last_q;
	logic [LEVEL_W-1:0]    peak_q;

	logic [LEVEL_W-1:0]     prev_rms_q;
	logic [WIN_SLOTS-1:0]   silent_mask_q;
	logic [WIN_SLOTS-1:0]   onset_hist_q;
	logic [TOTAL_W-1:0]     rms_total_q;
	logic [TOTAL_W-1:0]     peak_total_q;
	logic [LEVEL_W-1:0]     rms_max_q;
	logic [LEVEL_W-1:0]     peak_max_q;
	logic                   silent_q;
	logic                   onset_q;

	logic [LIMIT_W-1:0]  dv_q;
	logic [LIMIT_W-1:0]  ar_rem_q;
	logic [TOTAL_W-1:0]  ar_quo_q;
	logic [LIMIT_W-1:0]  ap_rem_q;
	logic [TOTAL_W-1:0]  ap_quo_q;

	logic                   out_valid_q;
	logic [WIN_W-1:0]       window_number_q;
	logic [LEVEL_W-1:0]     window_rms_q;
	logic [LEVEL_W-1:0]     window_peak_q;
	logic                   silent_flag_q;
	logic                   onset_flag_q;
	logic [WIN_SLOTS-1:0]   silent_bits_q;
	logic [WIN_SLOTS-1:0]   onset_bits_q;
	logic [LEVEL_W-1:0]     average_rms_q;
	logic [LEVEL_W-1:0]     average_peak_q;
	logic [LEVEL_W-1:0]     highest_rms_q;
	logic [LEVEL_W-1:0]     highest_peak_q;
	logic                   final_window_q;

	logic out_free;
	logic load_out;
	logic step_zero;

	logic [LEN_W:0]        div_sh;
	logic                  div_ge;
	logic [LEN_W-1:0]      div_rem;
	logic [MEAN_W-1:0]     quo_next;

	logic [ROOT_REM_W+1:0] rt_sh;
	logic [ROOT_REM_W+1:0] rt_trial;
	logic                  rt_ge;
	logic [ROOT_REM_W-1:0] rt_rem;
	logic [LEVEL_W-1:0]    root_next;

	logic                   first;
	logic                   silent;
	logic                   onset;
	logic [LEVEL_W:0]       rise_sum;
	logic [WIN_SLOTS-1:0]   win_bit;
	logic [TOTAL_W-1:0]     rms_total_next;
	logic [TOTAL_W-1:0]     peak_total_next;

	logic [LIMIT_W:0]   ar_sh;
	logic               ar_ge;
	logic [LIMIT_W-1:0] ar_rem;
	logic [LIMIT_W:0]   ap_sh;
	logic               ap_ge;
	logic [LIMIT_W-1:0] ap_rem;

	assign out_free  = !out_valid_q || !out_stall;
	assign step_zero = step_q == '0;

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: if (avail) state_next = ST_DIV;
			ST_DIV:  if (step_zero) state_next = ST_ROOT;
			ST_ROOT: if (step_zero) state_next = ST_UPD;
			ST_UPD:  state_next = ST_AVG;
			ST_AVG:  if (step_zero) state_next = ST_DONE;
			ST_DONE: if (out_free) state_next = ST_IDLE;
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: pop = avail;
			ST_DONE: load_out = out_free;
			default: begin
				pop      = 1'b0;
				load_out = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// mean square: restoring division, one quotient bit per cycle
	always_comb begin
		div_sh   = {rem_q, quo_q[MEAN_W-1]};
		div_ge   = div_sh >= {1'b0, den_q};
		div_rem  = div_ge ? LEN_W'(div_sh - {1'b0, den_q}) : div_sh[LEN_W-1:0];
		quo_next = {quo_q[MEAN_W-2:0], div_ge};
	end

	// square root: one result bit per cycle
	always_comb begin
		rt_sh     = {srem_q, rad_q[RAD_W-1:RAD_W-2]};
		rt_trial  = {2'b00, root_q, 2'b01};
		rt_ge     = rt_sh >= rt_trial;
		rt_rem    = rt_ge ? ROOT_REM_W'(rt_sh - rt_trial) : rt_sh[ROOT_REM_W-1:0];
		root_next = {root_q[LEVEL_W-2:0], rt_ge};
	end

	// window zero opens a run: drop what the previous run left behind
	always_comb begin
		first           = win_q == '0;
		silent          = root_q <= cfg.silence;
		rise_sum        = {1'b0, (first ? LEVEL_W'(0) : prev_rms_q)} + {1'b0, cfg.rise};
		onset           = !silent && ({1'b0, root_q} >= rise_sum);
		win_bit         = WIN_SLOTS'(1) << win_q;
		rms_total_next  = (first ? '0 : rms_total_q) + TOTAL_W'(root_q);
		peak_total_next = (first ? '0 : peak_total_q) + TOTAL_W'(peak_q);
	end

	// running means: two restoring dividers sharing one step count
	always_comb begin
		ar_sh  = {ar_rem_q, ar_quo_q[TOTAL_W-1]};
		ar_ge  = ar_sh >= {1'b0, dv_q};
		ar_rem = ar_ge ? LIMIT_W'(ar_sh - {1'b0, dv_q}) : ar_sh[LIMIT_W-1:0];
		ap_sh  = {ap_rem_q, ap_quo_q[TOTAL_W-1]};
		ap_ge  = ap_sh >= {1'b0, dv_q};
		ap_rem = ap_ge ? LIMIT_W'(ap_sh - {1'b0, dv_q}) : ap_sh[LIMIT_W-1:0];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (avail) begin
					den_q  <= job.count;
					rem_q  <= LEN_W'(job.acc[ACC_W-1:MEAN_W]);
					quo_q  <= job.acc[MEAN_W-1:0];
					win_q  <= job.win;
					last_q <= job.last;
					peak_q <= job.peak;
					step_q <= STEP_W'(DIV_STEPS - 1);
				end
			end
			ST_DIV: begin
				rem_q <= div_rem;
				quo_q <= quo_next;
				if (step_zero) begin
					rad_q  <= {1'b0, quo_next};
					srem_q <= '0;
					root_q <= '0;
					step_q <= STEP_W'(ROOT_STEPS - 1);
				end else begin
					step_q <= step_q - STEP_W'(1);
				end
			end
			ST_ROOT: begin
				srem_q <= rt_rem;
				root_q <= root_next;
				rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
				step_q <= step_q - STEP_W'(1);
			end
			ST_UPD: begin
				silent_q      <= silent;
				onset_q       <= onset;
				prev_rms_q    <= root_q;
				silent_mask_q <= (first ? '0 : silent_mask_q) | (silent ? win_bit : '0);
				onset_hist_q  <= (first ? '0 : onset_hist_q) | (onset ? win_bit : '0);
				rms_total_q   <= rms_total_next;
				peak_total_q  <= peak_total_next;
				rms_max_q     <= (!first && rms_max_q > root_q) ? rms_max_q : root_q;
				peak_max_q    <= (!first && peak_max_q > peak_q) ? peak_max_q : peak_q;
				dv_q          <= {1'b0, win_q} + LIMIT_W'(1);
				ar_rem_q      <= '0;
				ar_quo_q      <= rms_total_next;
				ap_rem_q      <= '0;
				ap_quo_q      <= peak_total_next;
				step_q        <= STEP_W'(AVG_STEPS - 1);
			end
			ST_AVG: begin
				ar_rem_q <= ar_rem;
				ar_quo_q <= {ar_quo_q[TOTAL_W-2:0], ar_ge};
				ap_rem_q <= ap_rem;
				ap_quo_q <= {ap_quo_q[TOTAL_W-2:0], ap_ge};
				step_q   <= step_q - STEP_W'(1);
			end
			default: begin
				step_q <= step_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			window_number_q <= win_q;
			window_rms_q    <= prev_rms_q;
			window_peak_q   <= peak_q;
			silent_flag_q   <= silent_q;
			onset_flag_q    <= onset_q;
			silent_bits_q   <= silent_mask_q;
			onset_bits_q    <= onset_hist_q;
			average_rms_q   <= ar_quo_q[LEVEL_W-1:0];
			average_peak_q  <= ap_quo_q[LEVEL_W-1:0];
			highest_rms_q   <= rms_max_q;
			highest_peak_q  <= peak_max_q;
			final_window_q  <= last_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign window_number = window_number_q;
	assign window_rms    = window_rms_q;
	assign window_peak   = window_peak_q;
	assign silent_flag   = silent_flag_q;
	assign onset_flag    = onset_flag_q;
	assign silent_bits   = silent_bits_q;
	assign onset_bits    = onset_bits_q;
	assign average_rms   = average_rms_q;
	assign average_peak  = average_peak_q;
	assign highest_rms   = highest_rms_q;
	assign highest_peak  = highest_peak_q;
	assign final_window  = final_window_q;

endmodule

FILE: design/window_level_onset_analyzer_top.sv
// Channel  Handshake            Payload
// in       in_valid / in_stall  sample
// out      out_valid/ out_stall window_number .. final_window (12 fields)
// cfg      cfg_valid/ cfg_ready cfg_index, cfg_data
//
// Samples are taken one per cycle unless in_stall; a closing window is queued the cycle after.
// Each closed window passes through the back end's mean-square divider, then the square root,
// then the running-mean dividers, with idle, update and done control states around them.
// The four-entry window queue absorbs bursts; in_stall rises when it has one free slot left.
// Reset clears counters, queue and handshake state; config registers return to defaults.
// out_stall holds the output register; the back end keeps one finished window waiting.
module window_level_onset_analyzer_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [wloa_pkg::SAMPLE_W-1:0] sample,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [wloa_pkg::WIN_W-1:0]           window_number,
	output logic [wloa_pkg::LEVEL_W-1:0]         window_rms,
	output logic [wloa_pkg::LEVEL_W-1:0]         window_peak,
	output logic                                 silent_flag,
	output logic                                 onset_flag,
	output logic [wloa_pkg::WIN_SLOTS-1:0]       silent_bits,
	output logic [wloa_pkg::WIN_SLOTS-1:0]       onset_bits,
	output logic [wloa_pkg::LEVEL_W-1:0]         average_rms,
	output logic [wloa_pkg::LEVEL_W-1:0]         average_peak,
	output logic [wloa_pkg::LEVEL_W-1:0]         highest_rms,
	output logic [wloa_pkg::LEVEL_W-1:0]         highest_peak,
	output logic                                 final_window,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [wloa_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [wloa_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import wloa_pkg::*;

	logic [RUN_W-1:0]   samples_per_run_q;
	logic [LEN_W-1:0]   window_length_q;
	logic [LIMIT_W-1:0] window_limit_q;
	logic [LEVEL_W-1:0] silence_level_q;
	logic [LEVEL_W-1:0] onset_rise_q;

	front_cfg_t front_cfg;
	back_cfg_t  back_cfg;

	logic near_full;
	logic push;
	job_t push_job;
	logic pop;
	logic avail;
	job_t pop_job;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samples_per_run_q <= RESET_SAMPLES_PER_RUN;
			window_length_q   <= RESET_WINDOW_LENGTH;
			window_limit_q    <= RESET_WINDOW_LIMIT;
			silence_level_q   <= RESET_SILENCE_LEVEL;
			onset_rise_q      <= RESET_ONSET_RISE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SAMPLES_PER_RUN: samples_per_run_q <= cfg_data[RUN_W-1:0];
				CFG_WINDOW_LENGTH:   window_length_q   <= cfg_data[LEN_W-1:0];
				CFG_WINDOW_LIMIT:    window_limit_q    <= cfg_data[LIMIT_W-1:0];
				CFG_SILENCE_LEVEL:   silence_level_q   <= cfg_data[LEVEL_W-1:0];
				CFG_ONSET_RISE:      onset_rise_q      <= cfg_data[LEVEL_W-1:0];
				default:             onset_rise_q      <= onset_rise_q;
			endcase
		end
	end

	assign front_cfg.run_len   = samples_per_run_q;
	assign front_cfg.win_len   = window_length_q;
	assign front_cfg.win_limit = window_limit_q;
	assign back_cfg.silence    = silence_level_q;
	assign back_cfg.rise       = onset_rise_q;

	wloa_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.sample          (sample),
		.cfg             (front_cfg),
		.queue_near_full (near_full),
		.push            (push),
		.push_job        (push_job)
	);

	wloa_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.near_full (near_full),
		.pop       (pop),
		.avail     (avail),
		.pop_job   (pop_job)
	);

	wloa_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (back_cfg),
		.avail         (avail),
		.job           (pop_job),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.window_number (window_number),
		.window_rms    (window_rms),
		.window_peak   (window_peak),
		.silent_flag   (silent_flag),
		.onset_flag    (onset_flag),
		.silent_bits   (silent_bits),
		.onset_bits    (onset_bits),
		.average_rms   (average_rms),
		.average_peak  (average_peak),
		.highest_rms   (highest_rms),
		.highest_peak  (highest_peak),
		.final_window  (final_window)
	);

endmodule
